// ===== sv/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and functions of the SHA-256 message hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int WordW  = 32;
    localparam int SchedD = 16;
    localparam int SchedA = 4;
    localparam int CountW = 61;

    localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
    localparam logic [CountW-1:0] CountOne = {{(CountW-1){1'b0}}, 1'b1};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } state_t;

    typedef logic [WordW-1:0] word_t;

    typedef struct packed {
        logic          wr_en;
        logic [SchedA-1:0] wr_addr;
        word_t         wr_data;
        logic [SchedA-1:0] rd_addr;
    } sched_req_t;

    function automatic word_t init_hash(input logic [2:0] i);
        word_t r;
        case (i)
            3'd0: r = 32'h6a09e667;
            3'd1: r = 32'hbb67ae85;
            3'd2: r = 32'h3c6ef372;
            3'd3: r = 32'ha54ff53a;
            3'd4: r = 32'h510e527f;
            3'd5: r = 32'h9b05688c;
            3'd6: r = 32'h1f83d9ab;
            default: r = 32'h5be0cd19;
        endcase
        return r;
    endfunction

    localparam word_t RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (WordW - n));
    endfunction

    function automatic word_t bsig0(input word_t x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction
    function automatic word_t bsig1(input word_t x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction
    function automatic word_t ssig0(input word_t x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction
    function automatic word_t ssig1(input word_t x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

// ===== sv/sha256_message_hasher_top.sv =====
// ----------------------------------------------------------------------------
// sha256_message_hasher_top
// SHA-256 over a byte stream, digest as eight 32-bit beats.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one beat per item. tdata[7:0] is the message byte,
//   tuser marks it as present, tlast ends the message. A beat with tuser low
//   and tlast high closes a message without adding a byte.
//   Master channel: eight beats per message, tdata[31:0] digest word,
//   tdata[34:32] its index; tlast flags the final word.
// Flow: bytes are taken while the block buffer fills; the 64th byte of a
//   block starts the schedule read lead-in, then 64 rounds of the shared
//   round unit, then the fold into the hash words; no byte is taken meanwhile.
// Digest: padding writes one schedule word a cycle, then compresses one or
//   two blocks before the first digest beat is offered; the remaining seven
//   follow one a cycle when not stalled.
// Reset: aresetn low loads the initial hash values and clears counters.
//   The schedule RAM is not cleared: every entry is written before it is read.
// Stall: while m_tready is low, hold the current digest beat; no new slave
//   beat is taken until the eighth digest beat has gone.
// ----------------------------------------------------------------------------
module sha256_message_hasher_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] byte_present
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic        m_tlast    // last_word
);
    typedef logic [31:0] w_t;

    sha_pkg::state_t state_reg, state_next;

    w_t   hash_reg [8];
    w_t   var_reg  [8];
    logic [sha_pkg::CountW-1:0] count_reg;
    logic [5:0] fill_reg;        // byte position inside the block
    w_t   part_reg;              // word being assembled
    logic [6:0] round_reg;       // 0..1 lead-in reads, 2..65 rounds
    logic [3:0] pad_reg;         // pad word position
    logic       fin_reg;         // padding in progress for this message
    logic       tail_reg;        // message ended with the byte that filled a block
    logic       done_reg;        // block under compression carries the length
    logic       mark_reg;        // 0x80 marker word still to be written
    logic       len_ok_reg;      // length words go into the block being padded
    logic [3:0] pad_first_reg;   // word that carries the marker
    w_t         pad_first_word_reg;
    logic [2:0] emit_reg;

    // expansion taps kept in registers
    w_t   wold_reg;              // W[r-16], captured from RAM copy A
    w_t   wm1_reg;               // W[r-1]
    w_t   wm2_reg;               // W[r-2]

    // schedule interface
    sha_pkg::sched_req_t req;
    logic [3:0] rd_b;
    w_t wa, wb;

    sha_sched u_sched (
        .aclk(aclk), .req(req), .rd_b(rd_b), .wa(wa), .wb(wb));

    logic s_acc, m_acc;
    assign s_tready = (state_reg == sha_pkg::ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = (state_reg == sha_pkg::ST_EMIT);
    assign m_acc    = m_tvalid && m_tready;
    assign m_tdata  = {5'd0, emit_reg, hash_reg[emit_reg]};
    assign m_tlast  = (emit_reg == 3'd7);

    // byte insertion, big-endian within the word
    logic [1:0] bpos;
    w_t         word_ins;
    assign bpos = fill_reg[1:0];
    always_comb begin
        word_ins = part_reg;
        case (bpos)
            2'd0: word_ins = {s_tdata, 24'd0};
            2'd1: word_ins[23:16] = s_tdata;
            2'd2: word_ins[15:8]  = s_tdata;
            default: word_ins[7:0] = s_tdata;
        endcase
    end

    // end of message: block position after the optional byte, marker word
    logic [5:0] end_pos;
    w_t         mark_base;
    w_t         mark_word;
    always_comb begin
        end_pos   = s_tuser ? fill_reg + 6'd1 : fill_reg;
        mark_base = s_tuser ? word_ins : part_reg;
        case (end_pos[1:0])
            2'd0: mark_word = 32'h8000_0000;
            2'd1: mark_word = {mark_base[31:24], 24'h80_0000};
            2'd2: mark_word = {mark_base[31:16], 16'h8000};
            default: mark_word = {mark_base[31:8], 8'h80};
        endcase
    end

    // padding word for the current pad position
    logic [63:0] bits;
    w_t          pad_word;
    assign bits = {count_reg, 3'd0};
    always_comb begin
        pad_word = 32'd0;
        if (mark_reg && pad_reg == pad_first_reg)  pad_word = pad_first_word_reg;
        else if (len_ok_reg && pad_reg == 4'd14)   pad_word = bits[63:32];
        else if (len_ok_reg && pad_reg == 4'd15)   pad_word = bits[31:0];
    end

    // Round unit. Copy A is read two rounds ahead: its output in round r is
    // slot r+1, i.e. W[r-15], and last cycle's output held in wold_reg is
    // W[r-16]. Copy B returns W[r-7]; W[r-2] comes from the register chain.
    logic [5:0] r;
    assign r = 6'(round_reg - 7'd2);
    w_t wexp, wcur, ch, mj, t1, t2;
    assign wexp = wold_reg + sha_pkg::ssig0(wa) + wb + sha_pkg::ssig1(wm2_reg);
    assign wcur = (r < 6'd16) ? wold_reg : wexp;
    assign ch = (var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]);
    assign mj = (var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2]) ^
                (var_reg[1] & var_reg[2]);
    assign t1 = var_reg[7] + sha_pkg::bsig1(var_reg[4]) + ch + sha_pkg::RoundK[r] + wcur;
    assign t2 = sha_pkg::bsig0(var_reg[0]) + mj;

    // next state
    logic blk_full;
    assign blk_full = (fill_reg == 6'd63);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sha_pkg::ST_IDLE: begin
                if (s_acc) begin
                    if (s_tuser && blk_full)  state_next = sha_pkg::ST_ROUND;
                    else if (s_tlast)         state_next = sha_pkg::ST_PAD;
                end
            end
            sha_pkg::ST_PAD: begin
                if (pad_reg == 4'd15) state_next = sha_pkg::ST_ROUND;
            end
            sha_pkg::ST_ROUND: begin
                if (round_reg == 7'd65) state_next = sha_pkg::ST_FOLD;
            end
            sha_pkg::ST_FOLD: begin
                if (done_reg)           state_next = sha_pkg::ST_EMIT;
                else if (fin_reg)       state_next = sha_pkg::ST_PAD;
                else                    state_next = sha_pkg::ST_IDLE;
            end
            sha_pkg::ST_EMIT: begin
                if (m_acc && emit_reg == 3'd7) state_next = sha_pkg::ST_IDLE;
            end
            default: state_next = sha_pkg::ST_IDLE;
        endcase
    end

    // schedule request; copy A's read address runs two rounds ahead of the round unit
    always_comb begin
        req.wr_en   = 1'b0;
        req.wr_addr = fill_reg[5:2];
        req.wr_data = word_ins;
        req.rd_addr = 4'(round_reg);
        rd_b        = 4'(round_reg + 7'd8);
        unique case (state_reg)
            sha_pkg::ST_IDLE: begin
                req.wr_en = s_acc && s_tuser;
            end
            sha_pkg::ST_PAD: begin
                req.wr_en   = 1'b1;
                req.wr_addr = pad_reg;
                req.wr_data = pad_word;
            end
            sha_pkg::ST_ROUND: begin
                req.wr_en   = (round_reg >= 7'd18);
                req.wr_addr = r[3:0];
                req.wr_data = wcur;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sha_pkg::ST_IDLE;
            for (int i = 0; i < 8; i++) begin
                hash_reg[i] <= sha_pkg::init_hash(3'(i));
                var_reg[i]  <= '0;
            end
            count_reg <= '0;
            fill_reg  <= '0;
            part_reg  <= '0;
            round_reg <= '0;
            pad_reg   <= '0;
            fin_reg   <= 1'b0;
            tail_reg  <= 1'b0;
            done_reg  <= 1'b0;
            mark_reg  <= 1'b0;
            emit_reg  <= '0;
            len_ok_reg <= 1'b0;
            pad_first_reg <= '0;
            pad_first_word_reg <= '0;
            wold_reg  <= '0;
            wm1_reg   <= '0;
            wm2_reg   <= '0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                sha_pkg::ST_IDLE: begin
                    if (s_acc) begin
                        if (s_tuser) begin
                            part_reg <= word_ins;
                            fill_reg <= fill_reg + 6'd1;
                            if (count_reg != sha_pkg::CountMax)
                                count_reg <= count_reg + sha_pkg::CountOne;
                        end
                        if (s_tlast) begin
                            // set up the padding of the current block
                            fin_reg            <= 1'b1;
                            tail_reg           <= s_tuser && blk_full;
                            mark_reg           <= 1'b1;
                            pad_first_reg      <= end_pos[5:2];
                            pad_reg            <= end_pos[5:2];
                            pad_first_word_reg <= mark_word;
                            len_ok_reg         <= (end_pos < 6'd56);
                        end
                    end
                end
                sha_pkg::ST_PAD: begin
                    pad_reg <= pad_reg + 4'd1;
                    if (pad_reg == 4'd15) begin
                        round_reg <= '0;
                        done_reg  <= len_ok_reg;
                    end
                end
                sha_pkg::ST_ROUND: begin
                    wold_reg <= wa;
                    if (round_reg == 7'd1) begin
                        for (int i = 0; i < 8; i++) var_reg[i] <= hash_reg[i];
                    end else if (round_reg >= 7'd2) begin
                        var_reg[7] <= var_reg[6];
                        var_reg[6] <= var_reg[5];
                        var_reg[5] <= var_reg[4];
                        var_reg[4] <= var_reg[3] + t1;
                        var_reg[3] <= var_reg[2];
                        var_reg[2] <= var_reg[1];
                        var_reg[1] <= var_reg[0];
                        var_reg[0] <= t1 + t2;
                        wm1_reg    <= wcur;
                        wm2_reg    <= wm1_reg;
                    end
                    round_reg <= round_reg + 7'd1;
                end
                sha_pkg::ST_FOLD: begin
                    for (int i = 0; i < 8; i++) hash_reg[i] <= hash_reg[i] + var_reg[i];
                    round_reg <= '0;
                    if (done_reg) begin
                        emit_reg <= '0;
                    end else if (tail_reg) begin
                        // full block ended the message: marker block set up at the end beat
                        tail_reg <= 1'b0;
                    end else if (fin_reg) begin
                        // marker already placed: zeros then length
                        mark_reg   <= 1'b0;
                        pad_reg    <= 4'd0;
                        len_ok_reg <= 1'b1;
                    end
                end
                sha_pkg::ST_EMIT: begin
                    if (m_acc) begin
                        emit_reg <= emit_reg + 3'd1;
                        if (emit_reg == 3'd7) begin
                            for (int i = 0; i < 8; i++)
                                hash_reg[i] <= sha_pkg::init_hash(3'(i));
                            count_reg <= '0;
                            fill_reg  <= '0;
                            fin_reg   <= 1'b0;
                            done_reg  <= 1'b0;
                            mark_reg  <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // assertions
    a_no_in_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != sha_pkg::ST_IDLE) |-> !s_tready)
        else $error("slave taken while busy");
    a_emit_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(emit_reg)))
        else $error("digest beat dropped under stall");
    a_round_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sha_pkg::ST_ROUND) |-> (round_reg <= 7'd65))
        else $error("round counter overran");
endmodule

// ===== sv/sha_ram.sv =====
// ----------------------------------------------------------------------------
// sha_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module sha_ram #(
    parameter int Width = 32,
    parameter int Depth = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(Depth)-1:0] wr_addr,
    input  logic [Width-1:0]         wr_data,
    input  logic [$clog2(Depth)-1:0] rd_addr,
    output logic [Width-1:0]         rd_data
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

// ===== sv/sha_sched.sv =====
// ----------------------------------------------------------------------------
// sha_sched
// Message schedule: two RAM copies of the 16-word window, one per RAM tap of
// the expansion. Writes go to both copies.
// ----------------------------------------------------------------------------
module sha_sched (
    input  logic                 aclk,
    input  sha_pkg::sched_req_t  req,
    input  logic [sha_pkg::SchedA-1:0] rd_b,
    output sha_pkg::word_t       wa,
    output sha_pkg::word_t       wb
);
    sha_ram #(.Width(sha_pkg::WordW), .Depth(sha_pkg::SchedD)) u_ra (
        .aclk(aclk), .wr_en(req.wr_en), .wr_addr(req.wr_addr),
        .wr_data(req.wr_data), .rd_addr(req.rd_addr), .rd_data(wa));
    sha_ram #(.Width(sha_pkg::WordW), .Depth(sha_pkg::SchedD)) u_rb (
        .aclk(aclk), .wr_en(req.wr_en), .wr_addr(req.wr_addr),
        .wr_data(req.wr_data), .rd_addr(rd_b), .rd_data(wb));
endmodule

// ===== bench/tb_sha256_message_hasher_top.sv =====
// ----------------------------------------------------------------------------
// tb_sha256_message_hasher_top
// Self-checking bench for the byte-stream SHA-256 hasher.
// ----------------------------------------------------------------------------
// Directed messages cover the empty message, single extreme bytes, a byte
// arriving with the end flag and ignored bytes. Random messages follow, with
// short lengths or lengths around the one- and two-block padding boundaries.
// A digest model predicts the eight digest beats of each message. Both
// channels idle at random.
// ----------------------------------------------------------------------------

class digest_board;
    sha_pkg::word_t hash_acc [8];
    sha_pkg::word_t msg_sched [16];
    int unsigned    fill_pos;
    logic [60:0]    byte_total;
    logic [39:0]    digest_q [$];
    logic           last_q [$];
    int             errors;

    function new();
        errors = 0;
        restart();
    endfunction

    function void restart();
        hash_acc = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                     32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
        fill_pos   = 0;
        byte_total = '0;
    endfunction

    function sha_pkg::word_t ror(sha_pkg::word_t x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
        sha_pkg::word_t v [8];
        sha_pkg::word_t w, t1, t2, ch, mj, s0, s1;
        for (int i = 0; i < 8; i++) v[i] = hash_acc[i];
        for (int r = 0; r < 64; r++) begin
            if (r >= 16) begin
                s0 = msg_sched[(r - 15) & 15];
                s1 = msg_sched[(r - 2) & 15];
                msg_sched[r & 15] = msg_sched[r & 15]
                    + (ror(s0, 7) ^ ror(s0, 18) ^ (s0 >> 3))
                    + msg_sched[(r - 7) & 15]
                    + (ror(s1, 17) ^ ror(s1, 19) ^ (s1 >> 10));
            end
            w  = msg_sched[r & 15];
            ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
            mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) + ch
                 + sha_pkg::RoundK[r] + w;
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) + mj;
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_acc[i] += v[i];
    endfunction

    function void put_byte(logic [7:0] b);
        int sh;
        sh = (3 - (fill_pos & 3)) * 8;
        msg_sched[fill_pos >> 2] = (msg_sched[fill_pos >> 2] & ~(32'hFF << sh))
                                   | (32'(b) << sh);
        fill_pos = (fill_pos + 1) & 63;
        if (fill_pos == 0) compress();
    endfunction

    // Note one accepted slave beat; queue the digest if it closes a message.
    function void note_beat(logic [7:0] b, logic present, logic eom);
        logic [63:0] bits;
        if (present) begin
            put_byte(b);
            if (byte_total != {61{1'b1}}) byte_total++;
        end
        if (!eom) return;
        put_byte(8'h80);
        while (fill_pos != 56) put_byte(8'h00);
        bits = {byte_total, 3'b000};
        for (int i = 7; i >= 0; i--) put_byte(bits[i*8 +: 8]);
        for (int i = 0; i < 8; i++) begin
            digest_q.push_back({5'b0, 3'(i), hash_acc[i]});
            last_q.push_back(i == 7);
        end
        restart();
    endfunction

    // Compare one digest beat with the oldest expectation.
    function void check_beat(logic [39:0] data, logic last);
        logic [39:0] exp_d;
        logic        exp_l;
        if (digest_q.size() == 0) begin
            $display("%0t: unexpected digest beat %h", $time, data);
            errors++;
            return;
        end
        exp_d = digest_q.pop_front();
        exp_l = last_q.pop_front();
        if (data[31:0] !== exp_d[31:0]) begin
            $display("%0t: digest word exp %h got %h", $time, exp_d[31:0], data[31:0]);
            errors++;
        end
        if (data[34:32] !== exp_d[34:32]) begin
            $display("%0t: word index exp %0d got %0d", $time, exp_d[34:32], data[34:32]);
            errors++;
        end
        if (data[39:35] !== 5'b0) begin
            $display("%0t: pad bits exp 0 got %b", $time, data[39:35]);
            errors++;
        end
        if (last !== exp_l) begin
            $display("%0t: last word exp %b got %b", $time, exp_l, last);
            errors++;
        end
    endfunction
endclass

module tb_sha256_message_hasher_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;

    digest_board board = new();
    int          cycles = 0;
    int          beats_sent = 0;
    bit          send_burst = 0;   // no idling between beats while set
    bit          recv_burst = 0;

    sha256_message_hasher_top i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Watchdog: abandon a hung run.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Sample digest beats at the rising edge, before the block updates.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_beat(m_tdata, m_tlast);
    end

    // Receiver: unless in burst mode, hold m_tready low for a random stretch, possibly none, before each digest beat.
    initial begin
        int k;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            k = recv_burst ? 0 : $urandom_range(0, 15);
            if (k > 0) begin
                m_tready = 1'b0;
                repeat (k) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            if ($urandom_range(0, 40) == 0) recv_burst = !recv_burst;
        end
    end

    // Drive one slave beat; valid drops only when a gap is drawn.
    task automatic send_beat(logic [7:0] b, logic present, logic eom);
        int gap;
        @(negedge aclk);
        gap = send_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tuser  = present;
        s_tlast  = eom;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        board.note_beat(b, present, eom);
        beats_sent++;
        if ($urandom_range(0, 30) == 0) send_burst = !send_burst;
    endtask

    // Send a message of random bytes, with a sprinkling of empty beats.
    task automatic send_message(int len);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
            send_beat(8'($urandom), 1'b1, (i == len - 1) && $urandom_range(0, 1));
        end
        // close with an empty beat unless the last byte already ended it
        if (len == 0 || !s_tlast) send_beat(8'($urandom), 1'b0, 1'b1);
    endtask

    // Drop valid and wait until every expected digest beat has arrived.
    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (board.digest_q.size() != 0) @(posedge aclk);
    endtask

    initial begin
        int len;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // empty message, then an ignored byte before another empty close
        send_beat(8'hA5, 1'b0, 1'b1);
        send_beat(8'hFF, 1'b0, 1'b0);
        send_beat(8'h5A, 1'b0, 1'b1);
        // one byte arriving together with the end flag, both extremes
        send_beat(8'h00, 1'b1, 1'b1);
        send_beat(8'hFF, 1'b1, 1'b1);
        // short message closed by an empty beat carrying stray data
        send_beat(8'h61, 1'b1, 1'b0);
        send_beat(8'h62, 1'b1, 1'b0);
        send_beat(8'h63, 1'b1, 1'b0);
        send_beat(8'hFF, 1'b0, 1'b1);
        // hold off until every digest beat is out
        drain();

        while (beats_sent < 150) begin
            case ($urandom_range(0, 4))
                0:       len = $urandom_range(54, 57);
                1:       len = $urandom_range(62, 65);
                default: len = $urandom_range(0, 12);
            endcase
            send_message(len);
            if ($urandom_range(0, 5) == 0) drain();
        end

        drain();
        repeat (300) @(posedge aclk);
        if (board.digest_q.size() != 0) begin
            $display("%0t: %0d digest beats never arrived", $time, board.digest_q.size());
            board.errors++;
        end
        if (board.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
